[sv/spa_pkg.sv]
// ----------------------------------------------------------------------------
// spa_pkg
// shared types and constants for the slot pool allocator
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

    // pool geometry
    localparam int SLOT_BYTES = 64;
    localparam int NUM_SLOTS  = 512;
    localparam int SLOT_SHIFT = $clog2(SLOT_BYTES);
    localparam int IDX_W      = $clog2(NUM_SLOTS);
    localparam int CNT_W      = 10;
    localparam int ADDR_W     = 32;

    // configuration register indexes
    localparam logic CFG_POOL_BASE  = 1'b0;
    localparam logic CFG_POOL_SLOTS = 1'b1;

    // result kinds
    localparam logic [2:0] KIND_NULL      = 3'd0;
    localparam logic [2:0] KIND_NEW_SLOT  = 3'd1;
    localparam logic [2:0] KIND_REUSED    = 3'd2;
    localparam logic [2:0] KIND_OVERSIZE  = 3'd3;
    localparam logic [2:0] KIND_POOL_FULL = 3'd4;
    localparam logic [2:0] KIND_UNCHANGED = 3'd5;

    // free kinds
    localparam logic [1:0] FREE_NONE   = 2'd0;
    localparam logic [1:0] FREE_POOL   = 2'd1;
    localparam logic [1:0] FREE_GLOBAL = 2'd2;

    typedef struct packed {
        logic              has_block;
        logic [ADDR_W-1:0] block_addr;
        logic [31:0]       old_size;
        logic [31:0]       new_size;
    } t_in_word;

    typedef struct packed {
        logic [2:0]        result_kind;
        logic [ADDR_W-1:0] result_addr;
        logic [1:0]        free_kind;
        logic [31:0]       copy_bytes;
        logic [CNT_W-1:0]  slots_in_use;
    } t_out_word;

    // one free-list link entry
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] next;
    } t_link;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

`default_nettype wire

[sv/spa_ctrl.sv]
// ----------------------------------------------------------------------------
// spa_ctrl
// request sequencer: accept, execute, hand result to output register
// ----------------------------------------------------------------------------
`default_nettype none

module spa_ctrl import spa_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire logic    i_out_stall,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd.load = i_in_valid && (r_state == S_IDLE);
        o_cmd.exec = (r_state == S_EXEC) && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (o_cmd.exec) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_goes_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC))
        else $error("accepted word did not move to execute");

    a_exec_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_out_valid)
        else $error("executed word not presented");

    a_blocked_exec_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_out_valid && i_out_stall) |=> (r_state == S_EXEC))
        else $error("execute left while output register was blocked");

endmodule

`default_nettype wire

[sv/spa_datapath.sv]
// ----------------------------------------------------------------------------
// spa_datapath
// free-list memory, allocator state, config registers and result register
// ----------------------------------------------------------------------------
`default_nettype none

module spa_datapath import spa_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [ADDR_W-1:0] i_cfg_data,
    input  wire t_in_word          i_in_word,
    input  wire t_dp_cmd           i_cmd,
    output t_out_word              o_out_word
);

    t_link mem_link [NUM_SLOTS];
    t_link r_rdata;

    t_in_word  r_req;
    t_out_word r_out;

    logic [ADDR_W-1:0] r_pool_base;
    logic [CNT_W-1:0]  r_pool_slots;
    logic [IDX_W-1:0]  r_free_head, n_free_head;
    logic              r_free_head_valid, n_free_head_valid;
    logic [CNT_W-1:0]  r_bump_index, n_bump_index;
    logic [CNT_W-1:0]  r_used_count, n_used_count;

    logic [CNT_W-1:0]  slot_cnt;
    logic              nz, op_same, op_take, op_give, oversize;
    logic              do_pop, do_bump, do_push, in_pool;
    logic [IDX_W-1:0]  head_a;
    logic              valid_a;
    logic [ADDR_W:0]   pool_hi;
    logic [ADDR_W-1:0] offset;
    logic [IDX_W-1:0]  push_idx;
    logic [CNT_W-1:0]  take_idx;
    logic [ADDR_W-1:0] slot_addr;
    logic [CNT_W-1:0]  used_a;
    t_link             wr_link;
    t_out_word         res;

    assign slot_cnt = (r_pool_slots > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : r_pool_slots;

    // request decode
    assign nz       = (r_req.new_size != 32'd0);
    assign op_same  = nz && r_req.has_block && (r_req.old_size == r_req.new_size);
    assign op_take  = nz && !op_same;
    assign op_give  = r_req.has_block && !op_same;
    assign oversize = (r_req.new_size > 32'(SLOT_BYTES));

    // allocation side
    assign do_pop  = op_take && !oversize && r_free_head_valid;
    assign do_bump = op_take && !oversize && !r_free_head_valid && (r_bump_index < slot_cnt);
    assign head_a  = do_pop ? r_rdata.next  : r_free_head;
    assign valid_a = do_pop ? r_rdata.valid : r_free_head_valid;

    assign take_idx  = do_pop ? CNT_W'(r_free_head) : r_bump_index;
    assign slot_addr = r_pool_base + (ADDR_W'(take_idx) << SLOT_SHIFT);

    // release side, end bound excluded
    assign pool_hi  = {1'b0, r_pool_base} + ((ADDR_W+1)'(slot_cnt) << SLOT_SHIFT);
    assign in_pool  = (r_req.old_size <= 32'(SLOT_BYTES)) && (r_req.block_addr >= r_pool_base)
                      && ({1'b0, r_req.block_addr} < pool_hi);
    assign offset   = r_req.block_addr - r_pool_base;
    assign push_idx = offset[SLOT_SHIFT +: IDX_W];
    assign do_push  = op_give && in_pool;

    always_comb begin
        wr_link.valid = valid_a;
        wr_link.next  = head_a;
    end

    always_comb begin
        used_a = r_used_count;
        if ((do_pop || do_bump) && (r_used_count != {CNT_W{1'b1}})) used_a = r_used_count + 1'b1;
        n_used_count = used_a;
        if (do_push && (used_a != '0)) n_used_count = used_a - 1'b1;

        n_free_head       = do_push ? push_idx : head_a;
        n_free_head_valid = do_push ? 1'b1     : valid_a;
        n_bump_index      = do_bump ? r_bump_index + 1'b1 : r_bump_index;
    end

    always_comb begin
        res.result_kind  = KIND_NULL;
        res.result_addr  = '0;
        res.free_kind    = FREE_NONE;
        res.copy_bytes   = '0;
        res.slots_in_use = n_used_count;
        if (op_same) begin
            res.result_kind = KIND_UNCHANGED;
            res.result_addr = r_req.block_addr;
        end else if (op_take) begin
            if (oversize) begin
                res.result_kind = KIND_OVERSIZE;
            end else if (do_pop) begin
                res.result_kind = KIND_REUSED;
                res.result_addr = slot_addr;
            end else if (do_bump) begin
                res.result_kind = KIND_NEW_SLOT;
                res.result_addr = slot_addr;
            end else begin
                res.result_kind = KIND_POOL_FULL;
            end
            if (r_req.has_block) begin
                res.copy_bytes = (r_req.old_size < r_req.new_size) ? r_req.old_size
                                                                    : r_req.new_size;
            end
        end
        if (op_give) begin
            res.free_kind = do_push ? FREE_POOL : FREE_GLOBAL;
        end
    end

    // link memory: one write on execute, one read at accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_push) begin
            mem_link[push_idx] <= wr_link;
        end
        if (i_cmd.load) begin
            r_rdata <= mem_link[r_free_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_in_word;
        if (i_cmd.exec) r_out <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base       <= '0;
            r_pool_slots      <= CNT_W'(NUM_SLOTS);
            r_free_head       <= '0;
            r_free_head_valid <= 1'b0;
            r_bump_index      <= '0;
            r_used_count      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POOL_BASE:  r_pool_base  <= i_cfg_data;
                    CFG_POOL_SLOTS: r_pool_slots <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                r_free_head       <= n_free_head;
                r_free_head_valid <= n_free_head_valid;
                r_bump_index      <= n_bump_index;
                r_used_count      <= n_used_count;
            end
        end
    end

    assign o_out_word = r_out;

    a_bump_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bump_index <= CNT_W'(NUM_SLOTS))
        else $error("bump index ran past the pool");

    a_push_sets_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && do_push) |=> r_free_head_valid)
        else $error("free list empty right after a slot release");

    a_state_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> ($stable(r_used_count) && $stable(r_bump_index)))
        else $error("allocator state changed outside execute");

endmodule

`default_nettype wire

[sv/slot_pool_allocator.sv]
// ----------------------------------------------------------------------------
// slot_pool_allocator
// fixed-size slot pool with lifo free list and bump fill of untouched slots
// result word: registered in execute once the output register is free
// a new request word is taken only after execute: the link memory read at
//   accept is followed by the head update and link write in execute
// a finished result waits in the output register while the next word is taken
// reset (synchronous, active low) empties the free list, clears bump index and
//   use count, and sets pool_base to 0 and pool_slots to 512; no memory sweep
// ----------------------------------------------------------------------------
`default_nettype none

module slot_pool_allocator import spa_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration write port
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [ADDR_W-1:0] i_cfg_data,
    // request words
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_word          i_in_word,
    // result words
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_word              o_out_word
);

    // load: capture request and read link at current head
    // exec: pop / bump / push and register the result word
    t_dp_cmd cmd;

    spa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    spa_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
